// ----- rtl/mlf_pkg.sv -----
// Package for the motion and light controlled LED fader.
// Holds operation and phase codes, register indexes and the duty table.
// No dependencies.
`default_nettype none

package mlf_pkg;

  localparam int unsigned LevelSteps = 128;
  localparam int unsigned LevelW     = $clog2(LevelSteps);
  localparam logic [LevelW-1:0] LevelTop = LevelW'(LevelSteps - 1);
  localparam logic [7:0] NightMinThreshold = 8'd5;
  localparam logic [2:0] PressTicks = 3'd5;

  localparam int unsigned PaddrW = 4;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_MOTION = 2'd1,
    OP_BUTTON = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_FADEIN  = 2'd1,
    PH_GLOW    = 2'd2,
    PH_FADEOUT = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    REG_ON_TIME   = 2'd0,
    REG_MAX_LEVEL = 2'd1,
    REG_DARK_THR  = 2'd2,
    REG_FADE_STEP = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] pwm_duty;
  } duty_t;

  localparam logic [7:0] DutyTable [LevelSteps] = '{
    8'd0,   8'd0,   8'd1,   8'd1,   8'd1,   8'd1,   8'd2,   8'd2,
    8'd2,   8'd2,   8'd2,   8'd3,   8'd3,   8'd3,   8'd3,   8'd4,
    8'd4,   8'd4,   8'd4,   8'd4,   8'd5,   8'd5,   8'd5,   8'd5,
    8'd6,   8'd6,   8'd6,   8'd6,   8'd6,   8'd7,   8'd7,   8'd7,
    8'd7,   8'd8,   8'd8,   8'd8,   8'd8,   8'd8,   8'd9,   8'd9,
    8'd9,   8'd9,   8'd10,  8'd10,  8'd10,  8'd10,  8'd10,  8'd11,
    8'd11,  8'd11,  8'd11,  8'd12,  8'd31,  8'd32,  8'd34,  8'd35,
    8'd36,  8'd38,  8'd39,  8'd41,  8'd42,  8'd44,  8'd45,  8'd47,
    8'd49,  8'd51,  8'd52,  8'd54,  8'd56,  8'd58,  8'd60,  8'd62,
    8'd64,  8'd66,  8'd68,  8'd70,  8'd72,  8'd75,  8'd77,  8'd79,
    8'd82,  8'd84,  8'd87,  8'd89,  8'd92,  8'd94,  8'd97,  8'd100,
    8'd103, 8'd105, 8'd108, 8'd111, 8'd114, 8'd117, 8'd120, 8'd124,
    8'd127, 8'd130, 8'd133, 8'd137, 8'd140, 8'd144, 8'd147, 8'd151,
    8'd155, 8'd158, 8'd162, 8'd166, 8'd170, 8'd174, 8'd178, 8'd182,
    8'd186, 8'd190, 8'd194, 8'd199, 8'd203, 8'd208, 8'd212, 8'd217,
    8'd221, 8'd226, 8'd231, 8'd236, 8'd241, 8'd246, 8'd251, 8'd255
  };

endpackage

`default_nettype wire

// ----- rtl/motion_light_fader_unit.sv -----
// Motion and light controlled LED fader, top level.
// Depends on mlf_pkg.
//
// Usage:
//   s_axis carries one request per event: tuser holds the operation (tick,
//   motion trigger, button pin change), tdata holds the light sample and the
//   button pin level. m_axis returns exactly one result per request: PWM
//   duty, light phase, lamp mode and night flag.
//   The APB port sets on-time, maximum level, dark threshold and fade step;
//   write it only while no request is in flight.
// Throughput and stage:
//   One request per cycle while s_axis_tready is high. A request accepted at
//   one edge updates the fader state and registers its result at that edge;
//   the phase machine, button debounce and table lookup all sit in one stage.
// Stall and reset:
//   A result register plus one skid entry decouple the sides: while the
//   receiver stalls, one more request is taken and held in the skid entry,
//   then s_axis_tready drops until the receiver drains it.
//   Reset clears the fader state, empties both output entries and restores
//   the register defaults (50, 127, 100, 5).
`default_nettype none

module motion_light_fader_unit
  import mlf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output      logic              s_axis_tready,
  input  wire logic [15:0]       s_axis_tdata,  // [7:0] light_sample, [8] button_low
  input  wire logic [1:0]        s_axis_tuser,  // [1:0] operation
  output      logic              m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output      logic [15:0]       m_axis_tdata,  // [7:0] pwm_duty, [9:8] light_state,
                                                // [10] lamp_mode_on, [11] is_dark
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output      logic [31:0]       prdata,
  output      logic              pready
);

  logic [7:0]        on_time_q;
  logic [LevelW-1:0] max_level_q;
  logic [7:0]        dark_thr_q;
  logic [LevelW-1:0] fade_step_q;

  phase_e            phase_q, phase_d;
  logic [LevelW-1:0] level_q, level_d;
  logic [7:0]        remaining_q, remaining_d;
  logic              hold_q, hold_d;
  logic              pending_q, pending_d;
  logic [2:0]        count_q, count_d;
  logic              is_dark;
  logic [7:0]        duty_q, duty_d;

  logic              out_valid_q, skid_valid_q;
  logic [15:0]       out_data_q, skid_data_q;
  logic [15:0]       result;

  op_e               op;
  logic [7:0]        sample;
  logic              pressed;
  logic              accept;
  logic              cfg_write;
  logic [LevelW:0]   sum;

  assign op      = op_e'(s_axis_tuser);
  assign sample  = s_axis_tdata[7:0];
  assign pressed = s_axis_tdata[8];

  assign s_axis_tready = !skid_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_write     = psel && penable && pwrite && pready;
  assign pready        = 1'b1;

  always_comb begin
    case (reg_idx_e'(paddr[3:2]))
      REG_ON_TIME:   prdata = {24'd0, on_time_q};
      REG_MAX_LEVEL: prdata = {25'd0, max_level_q};
      REG_DARK_THR:  prdata = {24'd0, dark_thr_q};
      REG_FADE_STEP: prdata = {25'd0, fade_step_q};
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_time_q   <= 8'd50;
      max_level_q <= LevelTop;
      dark_thr_q  <= 8'd100;
      fade_step_q <= LevelW'(5);
    end else if (cfg_write) begin
      case (reg_idx_e'(paddr[3:2]))
        REG_ON_TIME:   on_time_q   <= pwdata[7:0];
        REG_MAX_LEVEL: max_level_q <= pwdata[LevelW-1:0];
        REG_DARK_THR:  dark_thr_q  <= pwdata[7:0];
        REG_FADE_STEP: fade_step_q <= pwdata[LevelW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d     = phase_q;
    level_d     = level_q;
    remaining_d = remaining_q;
    hold_d      = hold_q;
    pending_d   = pending_q;
    count_d     = count_q;
    duty_d      = duty_q;
    sum         = {1'b0, level_q} + {1'b0, fade_step_q};

    is_dark = (dark_thr_q <= NightMinThreshold) ? 1'b1 : (sample > dark_thr_q);

    case (op)
      OP_TICK: begin
        case (phase_q)
          PH_FADEIN: begin
            if (level_q <= max_level_q) begin
              level_d = sum[LevelW] ? LevelTop : sum[LevelW-1:0];
              duty_d  = DutyTable[level_d];
            end
            if (level_d > max_level_q || level_d == LevelTop) begin
              phase_d = PH_GLOW;
            end
          end
          PH_GLOW: begin
            if (remaining_q != 8'd0) begin
              if (!hold_q) begin
                remaining_d = remaining_q - 8'd1;
              end
            end else begin
              phase_d = PH_FADEOUT;
            end
          end
          PH_FADEOUT: begin
            if (level_q > fade_step_q) begin
              level_d = level_q - fade_step_q;
            end else begin
              level_d = '0;
              phase_d = PH_IDLE;
            end
            duty_d = DutyTable[level_d];
          end
          default: ;
        endcase
        if (pending_q) begin
          count_d = count_q + 3'd1;
          if (count_d > PressTicks) begin
            pending_d = 1'b0;
            count_d   = 3'd0;
            if (pressed) begin
              if (hold_q && phase_d == PH_GLOW) begin
                hold_d      = 1'b0;
                remaining_d = 8'd0;
              end else begin
                hold_d      = 1'b1;
                remaining_d = on_time_q;
                phase_d     = PH_FADEIN;
              end
            end
          end
        end
      end
      OP_MOTION: begin
        if (phase_q == PH_IDLE && is_dark) begin
          phase_d = PH_FADEIN;
        end
        remaining_d = on_time_q;
      end
      OP_BUTTON: begin
        if (pressed) begin
          pending_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign result = {4'd0, is_dark, hold_d, phase_d, duty_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      level_q     <= '0;
      remaining_q <= 8'd0;
      hold_q      <= 1'b0;
      pending_q   <= 1'b0;
      count_q     <= 3'd0;
      duty_q      <= 8'd0;
    end else if (accept) begin
      phase_q     <= phase_d;
      level_q     <= level_d;
      remaining_q <= remaining_d;
      hold_q      <= hold_d;
      pending_q   <= pending_d;
      count_q     <= count_d;
      duty_q      <= duty_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_valid_q && m_axis_tready) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else if (!accept) begin
        out_valid_q <= 1'b0;
      end
    end else if (!out_valid_q) begin
      out_valid_q <= accept;
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_valid_q && m_axis_tready) begin
      if (skid_valid_q) begin
        out_data_q <= skid_data_q;
      end else if (accept) begin
        out_data_q <= result;
      end
    end else if (!out_valid_q) begin
      if (accept) begin
        out_data_q <= result;
      end
    end else if (accept) begin
      skid_data_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

// ----- rtl/mlf_checker.sv -----
// Port-level checker for the motion and light controlled LED fader.
// Depends on mlf_pkg; bound to motion_light_fader_unit below.
`default_nettype none

module mlf_checker
  import mlf_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_skid_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input blocked with empty output");

  a_idle_dark_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && phase_e'(m_axis_tdata[9:8]) == PH_IDLE |-> m_axis_tdata[7:0] == 8'd0)
    else $error("idle result with nonzero duty");

  a_request_yields_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted request left no result");

endmodule

bind motion_light_fader_unit mlf_checker u_mlf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ----- dv/motion_light_fader_unit_checker.sv -----
// Checker for the motion and light controlled LED fader: watches the request,
// result and register channels, predicts every result and compares it.
// Depends on mlf_pkg for codes, widths and the duty table.
`default_nettype none

module motion_light_fader_unit_checker
  import mlf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_tvalid_i,
  input  wire logic              s_tready_i,
  input  wire logic [15:0]       s_tdata_i,  // [7:0] light_sample, [8] button_low
  input  wire logic [1:0]        s_tuser_i,  // [1:0] operation
  input  wire logic              m_tvalid_i,
  input  wire logic              m_tready_i,
  input  wire logic [15:0]       m_tdata_i,  // [7:0] pwm_duty, [9:8] light_state,
                                             // [10] lamp_mode_on, [11] is_dark
  input  wire logic              psel_i,
  input  wire logic              penable_i,
  input  wire logic              pwrite_i,
  input  wire logic              pready_i,
  input  wire logic [PaddrW-1:0] paddr_i,
  input  wire logic [31:0]       pwdata_i,
  output int                     err_cnt_o,
  output int                     pending_o,
  output int                     checked_o
);

  typedef struct packed {
    logic       is_dark;
    logic       lamp_on;
    phase_e     state;
    logic [7:0] duty;
  } fader_out_t;

  logic [7:0] cfg_on_time;
  logic [6:0] cfg_max_level;
  logic [7:0] cfg_dark_thr;
  logic [6:0] cfg_fade_step;

  phase_e     cur_phase;
  logic [6:0] lvl;
  logic [7:0] on_left;
  logic       lamp_hold;
  logic       press_wait;
  logic [2:0] press_ticks;
  logic       night;
  logic [7:0] duty;

  fader_out_t expected_results [$];
  fader_out_t want;
  fader_out_t got;

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      err_cnt_o++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  task automatic advance_fader(input op_e op, input logic [7:0] sample,
                               input logic pressed);
    logic [7:0] sum;
    night = (cfg_dark_thr > NightMinThreshold) ? (sample > cfg_dark_thr) : 1'b1;
    case (op)
      OP_TICK: begin
        case (cur_phase)
          PH_FADEIN: begin
            if (lvl <= cfg_max_level) begin
              sum = {1'b0, lvl} + {1'b0, cfg_fade_step};
              lvl = (sum > {1'b0, LevelTop}) ? LevelTop : sum[6:0];
              duty = DutyTable[lvl];
            end
            if (lvl > cfg_max_level || lvl == LevelTop) cur_phase = PH_GLOW;
          end
          PH_GLOW: begin
            if (on_left != 8'd0) begin
              if (!lamp_hold) on_left = on_left - 8'd1;
            end else begin
              cur_phase = PH_FADEOUT;
            end
          end
          PH_FADEOUT: begin
            if (lvl > cfg_fade_step) begin
              lvl = lvl - cfg_fade_step;
            end else begin
              lvl = '0;
              cur_phase = PH_IDLE;
            end
            duty = DutyTable[lvl];
          end
          default: ;
        endcase
        if (press_wait) begin
          press_ticks = press_ticks + 3'd1;
          if (press_ticks > PressTicks) begin
            press_wait  = 1'b0;
            press_ticks = '0;
            if (pressed) begin
              if (lamp_hold && cur_phase == PH_GLOW) begin
                lamp_hold = 1'b0;
                on_left   = '0;
              end else begin
                lamp_hold = 1'b1;
                on_left   = cfg_on_time;
                cur_phase = PH_FADEIN;
              end
            end
          end
        end
      end
      OP_MOTION: begin
        if (cur_phase == PH_IDLE && night) cur_phase = PH_FADEIN;
        on_left = cfg_on_time;
      end
      OP_BUTTON: begin
        if (pressed) press_wait = 1'b1;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_on_time   = 8'd50;
      cfg_max_level = 7'd127;
      cfg_dark_thr  = 8'd100;
      cfg_fade_step = 7'd5;
      cur_phase     = PH_IDLE;
      lvl           = '0;
      on_left       = '0;
      lamp_hold     = 1'b0;
      press_wait    = 1'b0;
      press_ticks   = '0;
      night         = 1'b0;
      duty          = '0;
      expected_results.delete();
      err_cnt_o     = 0;
      checked_o     = 0;
      pending_o     = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got = fader_out_t'(m_tdata_i[11:0]);
        if (expected_results.size() == 0) begin
          err_cnt_o++;
          $display("%0t: result with none expected, actual 0x%03h", $time, m_tdata_i[11:0]);
        end else begin
          want = expected_results.pop_front();
          check_field("pwm_duty", want.duty, got.duty);
          check_field("light_state", want.state, got.state);
          check_field("lamp_mode_on", want.lamp_on, got.lamp_on);
          check_field("is_dark", want.is_dark, got.is_dark);
          checked_o++;
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[PaddrW-1:2]))
          REG_ON_TIME:   cfg_on_time   = pwdata_i[7:0];
          REG_MAX_LEVEL: cfg_max_level = pwdata_i[6:0];
          REG_DARK_THR:  cfg_dark_thr  = pwdata_i[7:0];
          REG_FADE_STEP: cfg_fade_step = pwdata_i[6:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        advance_fader(op_e'(s_tuser_i), s_tdata_i[7:0], s_tdata_i[8]);
        want.duty    = duty;
        want.state   = cur_phase;
        want.lamp_on = lamp_hold;
        want.is_dark = night;
        expected_results.push_back(want);
      end
      pending_o = expected_results.size();
    end
  end

endmodule

`default_nettype wire

// ----- dv/motion_light_fader_unit_tb.sv -----
// Testbench top for the motion and light controlled LED fader: drives events
// and register writes, stalls both stream sides and gives the verdict.
// Depends on mlf_pkg, motion_light_fader_unit and its checker.
`default_nettype none

module motion_light_fader_unit_tb;
  import mlf_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int PhaseItems    = 300;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              s_axis_tvalid;
  wire logic         s_axis_tready;
  logic [15:0]       s_axis_tdata;   // [7:0] light_sample, [8] button_low
  logic [1:0]        s_axis_tuser;   // [1:0] operation
  wire logic         m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  wire logic [15:0]  m_axis_tdata;   // [7:0] pwm_duty, [9:8] light_state,
                                     // [10] lamp_mode_on, [11] is_dark
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0]       pwdata;
  wire logic [31:0]  prdata;
  wire logic         pready;

  int          err_cnt;
  int          pending;
  int          checked;
  int          n_sent;
  int          op_cnt [4];
  int          n_settings;
  int          stall_cnt = 0;
  logic        quiet;
  logic [7:0]  cur_thr;

  motion_light_fader_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  motion_light_fader_unit_checker fader_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .pready_i   (pready),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .err_cnt_o  (err_cnt),
    .pending_o  (pending),
    .checked_o  (checked)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= quiet || ($urandom_range(99) >= 11);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
    if (stall_cnt >= WatchdogLimit) begin
      $display("%0t: no progress for %0d cycles", $time, WatchdogLimit);
      $display("motion_light_fader_unit_tb NOT OK");
      $finish;
    end
  end

  task automatic send_req(input op_e op, input logic [7:0] sample, input logic pressed);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, pressed, sample};
    s_axis_tuser  <= op;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    n_sent++;
    op_cnt[op]++;
    if (!quiet && $urandom_range(99) < 11) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic wait_results();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic apb_write(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_settings(input logic [7:0] on_time, input logic [6:0] max_lvl,
                               input logic [7:0] thr, input logic [6:0] step);
    wait_results();
    apb_write(REG_ON_TIME, {24'd0, on_time});
    apb_write(REG_MAX_LEVEL, {25'd0, max_lvl});
    apb_write(REG_DARK_THR, {24'd0, thr});
    apb_write(REG_FADE_STEP, {25'd0, step});
    cur_thr = thr;
    n_settings++;
  endtask

  function automatic logic [7:0] night_sample();
    if (cur_thr < 8'd255 && $urandom_range(1) == 1) begin
      return 8'($urandom_range(255, int'(cur_thr) + 1));
    end
    return 8'($urandom_range(255));
  endfunction

  task automatic run_traffic(input int n_items);
    int stop_at;
    int pick;
    stop_at = n_sent + n_items;
    while (n_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        send_req(OP_MOTION, night_sample(), 1'($urandom_range(1)));
        repeat ($urandom_range(40, 3)) begin
          send_req(OP_TICK, night_sample(), $urandom_range(9) == 0);
        end
      end else if (pick < 70) begin
        send_req(OP_BUTTON, 8'($urandom_range(255)), 1'b1);
        repeat (5) send_req(OP_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
        send_req(OP_TICK, night_sample(), $urandom_range(3) != 0);
        repeat ($urandom_range(10)) send_req(OP_TICK, night_sample(), 1'b0);
      end else begin
        repeat ($urandom_range(8, 1)) begin
          send_req(op_e'($urandom_range(3)), 8'($urandom_range(255)),
                   1'($urandom_range(1)));
        end
      end
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_TICK;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    quiet         = 1'b0;
    cur_thr       = 8'd100;
    n_sent        = 0;
    n_settings    = 0;
    foreach (op_cnt[i]) op_cnt[i] = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_req(OP_NONE, 8'd255, 1'b1);
    send_req(OP_NONE, 8'd0, 1'b0);
    send_req(OP_TICK, 8'd0, 1'b0);
    send_req(OP_MOTION, 8'd100, 1'b0);
    send_req(OP_MOTION, 8'd101, 1'b0);
    repeat (3) send_req(OP_TICK, 8'd255, 1'b0);
    send_req(OP_BUTTON, 8'd200, 1'b0);
    send_req(OP_BUTTON, 8'd200, 1'b1);
    repeat (5) send_req(OP_TICK, 8'd150, 1'b1);
    send_req(OP_TICK, 8'd150, 1'b1);
    send_req(OP_TICK, 8'd0, 1'b0);
    load_settings(8'd0, 7'd127, 8'd5, 7'd0);
    send_req(OP_MOTION, 8'd0, 1'b0);
    repeat (3) send_req(OP_TICK, 8'd0, 1'b0);
    load_settings(8'd0, 7'd0, 8'd0, 7'd0);
    repeat (4) send_req(OP_TICK, 8'd0, 1'b0);

    load_settings(8'd50, 7'd127, 8'd100, 7'd5);
    run_traffic(PhaseItems / 2);
    wait_results();
    run_traffic(PhaseItems / 2);
    load_settings(8'd0, 7'd0, 8'd0, 7'd127);
    run_traffic(PhaseItems);
    quiet = 1'b1;
    load_settings(8'd255, 7'd127, 8'd5, 7'd1);
    run_traffic(PhaseItems);
    quiet = 1'b0;
    load_settings(8'($urandom_range(20)), 7'($urandom_range(127)), 8'd255,
                  7'($urandom_range(127, 1)));
    run_traffic(PhaseItems);
    repeat (2) begin
      load_settings(8'($urandom_range(30)), 7'($urandom_range(127)),
                    8'($urandom_range(255)), 7'($urandom_range(127, 1)));
      run_traffic(PhaseItems);
    end

    wait_results();
    repeat (4) @(posedge clk_i);
    $display("Covered %0d requests (tick %0d, motion %0d, button %0d, no-op %0d)",
             n_sent, op_cnt[OP_TICK], op_cnt[OP_MOTION], op_cnt[OP_BUTTON], op_cnt[OP_NONE]);
    $display("across %0d register settings, %0d results compared", n_settings, checked);
    if (err_cnt == 0 && pending == 0) begin
      $display("motion_light_fader_unit_tb OK");
    end else begin
      $display("motion_light_fader_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
